### rtl/daet_pkg.sv
// ----------------------------------------------------------------------------
// daet_pkg
// Shared types and field constants of the daily event alarm table.
// ----------------------------------------------------------------------------
package daet_pkg;

	localparam int KEY_W      = 28;
	localparam int HOUR_W     = 5;
	localparam int MIN_W      = 6;
	localparam int PAY_W      = 17;
	localparam int TIME_W     = HOUR_W + MIN_W;
	localparam int MIN_SHIFT  = 17;
	localparam int HOUR_SHIFT = 23;
	localparam int CMD_W      = 3;
	localparam int STAT_W     = 2;

	// stream word layouts
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 48;

	typedef enum logic [CMD_W-1:0] {
		CMD_SCHEDULE   = 3'd0,
		CMD_UNSCHEDULE = 3'd1,
		CMD_RESCHEDULE = 3'd2,
		CMD_EVALUATE   = 3'd3,
		CMD_CLEAR      = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_ALREADY   = 2'd1,
		ST_NOT_SCHED = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_INS,
		S_EVAL,
		S_RESP
	} state_t;

endpackage

### rtl/daily_event_alarm_table.sv
// ----------------------------------------------------------------------------
// daily_event_alarm_table
// Sorted table of daily events with schedule, unschedule, reschedule,
// evaluate and clear commands, one result word per command word.
// ----------------------------------------------------------------------------
// The table holds up to TABLE_DEPTH keys (hour, minute, 17-bit payload) in
// ascending order in a single-port-read memory, walked one entry per cycle by
// a small sequencer around one shared 28-bit magnitude comparator. A command
// word is taken only while the block is idle. Evaluate and unschedule walk the
// table in a forward search pass; schedule and reschedule follow their search
// pass with an insertion pass that shifts entries up, while clear and unknown
// commands go straight to the result. A finished result waits in the output
// register; the next command word is taken meanwhile.
// ----------------------------------------------------------------------------
module daily_event_alarm_table
	import daet_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// event_key[27:0], hour[32:28], minute[38:33], zero[39]
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// command[2:0]
	input  logic [CMD_W-1:0]    s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// status[1:0], fire[2], fire_payload[19:3], result_key[47:20]
	output logic [M_DATA_W-1:0] m_axis_tdata
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

	logic [KEY_W-1:0] mem [TABLE_DEPTH];

	state_t              state_q, state_d;
	cmd_t                cmd_q, cmd_d;
	logic [KEY_W-1:0]    ref_q, ref_d;
	logic [TIME_W-1:0]   now_q, now_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [KEY_W-1:0]    last_q, last_d;
	logic [CNT_W-1:0]    rd_ptr_q, rd_ptr_d;
	logic                valid_s1, valid_d;
	logic [CNT_W-1:0]    addr_s1, addr_d;
	logic [KEY_W-1:0]    rd_data_q;
	logic                found_q, found_d;
	logic [KEY_W-1:0]    first_q, first_d;
	logic [CNT_W-1:0]    hole_q, hole_d;
	logic [STAT_W-1:0]   res_status_q, res_status_d;
	logic                res_fire_q, res_fire_d;
	logic [PAY_W-1:0]    res_pay_q, res_pay_d;
	logic [KEY_W-1:0]    res_key_q, res_key_d;
	logic                m_valid_q, m_valid_d;
	logic [M_DATA_W-1:0] m_data_q, m_data_d;

	logic [CNT_W-1:0] rd_addr;
	logic             mem_we;
	logic [CNT_W-1:0] mem_waddr;
	logic [KEY_W-1:0] mem_wdata;

	logic             in_acc;
	logic             cmp_eq, cmp_gt;
	logic             issue, stop_now, due;
	logic [KEY_W-1:0] new_key;
	logic [CNT_W-1:0] cnt_dec;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	// shared comparator: table word against the reference key or time
	assign cmp_eq = (rd_data_q == ref_q);
	assign cmp_gt = (rd_data_q > ref_q);

	assign cnt_dec = cnt_q - 1'b1;
	assign new_key = {now_q, ref_q[PAY_W-1:0]};
	assign due     = (first_q[KEY_W-1:MIN_SHIFT] == now_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr[IDX_W-1:0]] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			last_q    <= '0;
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			last_q    <= last_d;
			valid_s1  <= valid_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		ref_q        <= ref_d;
		now_q        <= now_d;
		rd_ptr_q     <= rd_ptr_d;
		addr_s1      <= addr_d;
		found_q      <= found_d;
		first_q      <= first_d;
		hole_q       <= hole_d;
		res_status_q <= res_status_d;
		res_fire_q   <= res_fire_d;
		res_pay_q    <= res_pay_d;
		res_key_q    <= res_key_d;
		m_data_q     <= m_data_d;
	end

	always_comb begin
		state_d      = state_q;
		cmd_d        = cmd_q;
		ref_d        = ref_q;
		now_d        = now_q;
		cnt_d        = cnt_q;
		last_d       = last_q;
		rd_ptr_d     = rd_ptr_q;
		valid_d      = 1'b0;
		addr_d       = addr_s1;
		found_d      = found_q;
		first_d      = first_q;
		hole_d       = hole_q;
		res_status_d = res_status_q;
		res_fire_d   = res_fire_q;
		res_pay_d    = res_pay_q;
		res_key_d    = res_key_q;
		m_valid_d    = m_valid_q && !m_axis_tready;
		m_data_d     = m_data_q;
		rd_addr      = rd_ptr_q;
		mem_we       = 1'b0;
		mem_waddr    = '0;
		mem_wdata    = ref_q;
		issue        = 1'b0;
		stop_now     = 1'b0;
		s_axis_tready = 1'b0;

		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (in_acc) begin
					cmd_d        = cmd_t'(s_axis_tuser);
					now_d        = {s_axis_tdata[KEY_W +: HOUR_W],
					                s_axis_tdata[KEY_W + HOUR_W +: MIN_W]};
					ref_d        = s_axis_tdata[KEY_W-1:0];
					rd_ptr_d     = '0;
					found_d      = 1'b0;
					res_status_d = ST_OK;
					res_fire_d   = 1'b0;
					res_pay_d    = '0;
					res_key_d    = '0;
					case (cmd_t'(s_axis_tuser))
						CMD_SCHEDULE, CMD_UNSCHEDULE, CMD_RESCHEDULE: begin
							state_d = S_SCAN;
						end
						CMD_EVALUATE: begin
							ref_d   = {s_axis_tdata[KEY_W +: HOUR_W],
							           s_axis_tdata[KEY_W + HOUR_W +: MIN_W],
							           {MIN_SHIFT{1'b0}}};
							state_d = (cnt_q == '0) ? S_RESP : S_SCAN;
						end
						CMD_CLEAR: begin
							cnt_d   = '0;
							state_d = S_RESP;
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end

			S_SCAN: begin
				// forward walk, one entry per cycle
				if (valid_s1) begin
					if (addr_s1 == '0) begin
						first_d = rd_data_q;
					end
					case (cmd_q)
						CMD_SCHEDULE: stop_now = cmp_eq;
						CMD_EVALUATE: stop_now = cmp_eq || cmp_gt;
						default: begin
							// close the gap behind the removed entry
							if (found_q) begin
								mem_we    = 1'b1;
								mem_waddr = addr_s1 - 1'b1;
								mem_wdata = rd_data_q;
							end else if (cmp_eq) begin
								found_d = 1'b1;
							end
						end
					endcase
				end
				issue = (rd_ptr_q < cnt_q) && !stop_now;
				if (stop_now || (!valid_s1 && rd_ptr_q >= cnt_q)) begin
					issue = 1'b0;
					case (cmd_q)
						CMD_SCHEDULE: begin
							if (stop_now) begin
								res_status_d = ST_ALREADY;
								state_d      = S_RESP;
							end else if (cnt_q == FULL_CNT) begin
								res_status_d = ST_FULL;
								state_d      = S_RESP;
							end else begin
								rd_ptr_d = cnt_q;
								hole_d   = cnt_q;
								state_d  = S_INS;
							end
						end
						CMD_UNSCHEDULE: begin
							if (found_q) begin
								cnt_d = cnt_dec;
							end else begin
								res_status_d = ST_NOT_SCHED;
							end
							state_d = S_RESP;
						end
						CMD_RESCHEDULE: begin
							if (found_q) begin
								cnt_d     = cnt_dec;
								ref_d     = new_key;
								res_key_d = new_key;
								rd_ptr_d  = cnt_dec;
								hole_d    = cnt_dec;
								state_d   = S_INS;
							end else begin
								res_status_d = ST_NOT_SCHED;
								state_d      = S_RESP;
							end
						end
						default: begin
							// evaluate: hit entry, else wrap to the first one
							if (stop_now) begin
								first_d = rd_data_q;
							end
							state_d = S_EVAL;
						end
					endcase
				end else if (issue) begin
					rd_ptr_d = rd_ptr_q + 1'b1;
				end
				valid_d = issue;
				addr_d  = rd_ptr_q;
			end

			S_INS: begin
				// backward walk: shift larger entries up, drop the key in the gap
				rd_addr = rd_ptr_q - 1'b1;
				if (valid_s1) begin
					mem_we    = 1'b1;
					mem_waddr = addr_s1 + 1'b1;
					if (cmp_gt) begin
						mem_wdata = rd_data_q;
						hole_d    = addr_s1;
						issue     = (rd_ptr_q != '0);
					end else begin
						cnt_d   = cnt_q + 1'b1;
						state_d = S_RESP;
					end
				end else if (rd_ptr_q == '0) begin
					mem_we    = 1'b1;
					mem_waddr = hole_q;
					cnt_d     = cnt_q + 1'b1;
					state_d   = S_RESP;
				end else begin
					issue = 1'b1;
				end
				if (issue) begin
					rd_ptr_d = rd_ptr_q - 1'b1;
				end
				valid_d = issue;
				addr_d  = rd_ptr_q - 1'b1;
			end

			S_EVAL: begin
				if (due) begin
					if (last_q != first_q) begin
						res_fire_d = 1'b1;
						res_pay_d  = first_q[PAY_W-1:0];
						last_d     = first_q;
					end
				end else if (last_q == first_q) begin
					last_d = '0;
				end
				state_d = S_RESP;
			end

			S_RESP: begin
				// hold until the output register is free
				if (!m_valid_q || m_axis_tready) begin
					m_valid_d = 1'b1;
					m_data_d  = {res_key_q, res_pay_q, res_fire_q, res_status_q};
					state_d   = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("entry count beyond table depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("command word taken while busy");

	a_fire_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[STAT_W]) |->
		(m_axis_tdata[STAT_W-1:0] == ST_OK && m_axis_tdata[M_DATA_W-1:M_DATA_W-KEY_W] == '0))
		else $error("fire word carries status or result key");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SCAN || state_q == S_INS))
		else $error("table write outside search or insert pass");
`endif

endmodule

### dv/daily_event_alarm_table_tb.sv
// ----------------------------------------------------------------------------
// daily_event_alarm_table_tb
// Self-checking bench for the daily event alarm table. Command words enter on
// the slave stream in random bursts with random gaps. A behavioural copy of
// the sorted table predicts every result word, and each word on the master
// stream is compared field by field while the receiver stalls on its own
// changing pattern.
// ----------------------------------------------------------------------------
module daily_event_alarm_table_tb
	import daet_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH    = 16;
	localparam int CLK_HALF       = 2;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 60;
	localparam int RANDOM_ITEMS   = 720;

	// result word layout
	localparam int FIRE_BIT = STAT_W;
	localparam int PAY_LO   = STAT_W + 1;
	localparam int RKEY_LO  = PAY_LO + PAY_W;

	typedef struct packed {
		status_t          status;
		logic             fire;
		logic [PAY_W-1:0] payload;
		logic [KEY_W-1:0] new_key;
	} alarm_result_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata;
	logic [CMD_W-1:0]    s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [M_DATA_W-1:0] m_axis_tdata;

	// behavioural table and the results it still owes
	logic [KEY_W-1:0] sched_keys [TABLE_DEPTH];
	int               sched_count;
	logic [KEY_W-1:0] fired_key;
	alarm_result_t    awaited_results [$];

	int   cmd_count [8];
	int   fire_count;
	int   full_count;
	int   result_count;
	int   mismatch_count;
	int   hold_count;
	int   burst_left;
	int   stuck_cycles;
	logic hold_request;

	daily_event_alarm_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	function automatic logic [KEY_W-1:0] make_key(input logic [HOUR_W-1:0] hour,
			input logic [MIN_W-1:0] minute, input logic [PAY_W-1:0] payload);
		return {hour, minute, payload};
	endfunction

	function automatic int find_sched(input logic [KEY_W-1:0] key);
		for (int i = 0; i < sched_count; i++)
			if (sched_keys[i] == key)
				return i;
		return -1;
	endfunction

	function automatic void drop_sched(input int idx);
		for (int i = idx; i + 1 < sched_count; i++)
			sched_keys[i] = sched_keys[i + 1];
		sched_count--;
	endfunction

	function automatic void place_sched(input logic [KEY_W-1:0] key);
		int pos;
		pos = 0;
		if (sched_count >= TABLE_DEPTH)
			return;
		while (pos < sched_count && sched_keys[pos] <= key)
			pos++;
		for (int i = sched_count; i > pos; i--)
			sched_keys[i] = sched_keys[i - 1];
		sched_keys[pos] = key;
		sched_count++;
	endfunction

	// Apply one accepted command to the table and queue the result it owes.
	function automatic void predict_alarm(input logic [CMD_W-1:0] cmd,
			input logic [KEY_W-1:0] key, input logic [HOUR_W-1:0] hour,
			input logic [MIN_W-1:0] minute);
		alarm_result_t    res;
		int               idx;
		logic [KEY_W-1:0] cur;
		logic [TIME_W-1:0] now;
		res = '0;
		cmd_count[cmd]++;
		case (cmd)
		CMD_SCHEDULE: begin
			if (find_sched(key) >= 0) begin
				res.status = ST_ALREADY;
			end else if (sched_count >= TABLE_DEPTH) begin
				res.status = ST_FULL;
				full_count++;
			end else begin
				place_sched(key);
			end
		end
		CMD_UNSCHEDULE: begin
			idx = find_sched(key);
			if (idx < 0)
				res.status = ST_NOT_SCHED;
			else
				drop_sched(idx);
		end
		CMD_RESCHEDULE: begin
			idx = find_sched(key);
			if (idx < 0) begin
				res.status = ST_NOT_SCHED;
			end else begin
				res.new_key = {hour, minute, key[PAY_W-1:0]};
				drop_sched(idx);
				place_sched(res.new_key);
			end
		end
		CMD_EVALUATE: begin
			if (sched_count > 0) begin
				now = {hour, minute};
				cur = sched_keys[0];
				// first entry at or after now, else wrap to the first
				for (int i = 0; i < sched_count; i++) begin
					if (sched_keys[i][KEY_W-1:MIN_SHIFT] >= now) begin
						cur = sched_keys[i];
						break;
					end
				end
				if (cur[KEY_W-1:MIN_SHIFT] == now) begin
					if (fired_key != cur) begin
						res.fire    = 1'b1;
						res.payload = cur[PAY_W-1:0];
						fired_key   = cur;
						fire_count++;
					end
				end else if (fired_key == cur) begin
					fired_key = '0;
				end
			end
		end
		CMD_CLEAR: sched_count = 0;
		default: ;
		endcase
		awaited_results = {awaited_results, res};
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		logic [PAY_W-1:0]  payload;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		case ($urandom_range(0, 9))
		0: payload = '0;
		1: payload = '1;
		default: payload = PAY_W'($urandom);
		endcase
		if ($urandom_range(0, 9) == 0)
			return KEY_W'($urandom);
		// crowd the keys into a few slots so that times collide
		hour   = ($urandom_range(0, 2) == 0) ? HOUR_W'($urandom_range(0, 23))
			: HOUR_W'($urandom_range(6, 8));
		minute = ($urandom_range(0, 2) == 0) ? MIN_W'($urandom_range(0, 59))
			: MIN_W'($urandom_range(0, 3) * 15);
		return make_key(hour, minute, payload);
	endfunction

	// Time of an entry where it is a real time of day, else any time.
	function automatic void entry_time(input logic [KEY_W-1:0] key,
			output logic [HOUR_W-1:0] hour, output logic [MIN_W-1:0] minute);
		hour   = key[KEY_W-1:HOUR_SHIFT];
		minute = key[HOUR_SHIFT-1:MIN_SHIFT];
		if (hour > 23 || minute > 59) begin
			hour   = HOUR_W'($urandom_range(0, 23));
			minute = MIN_W'($urandom_range(0, 59));
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
			input logic [HOUR_W-1:0] hour, input logic [MIN_W-1:0] minute);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {1'b0, minute, hour, key};
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		predict_alarm(cmd, key, hour, minute);
	endtask

	// Hold the sender until every owed result has come back.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	task automatic test_directed();
		logic [KEY_W-1:0] k_morning;
		logic [KEY_W-1:0] k_seven;
		logic [KEY_W-1:0] k_eight;
		k_morning = make_key(5'd10, 6'd30, '1);
		k_seven   = make_key(5'd7, 6'd0, 17'd5);
		k_eight   = make_key(5'd8, 6'd0, 17'd5);
		send_word(CMD_EVALUATE, '0, 5'd0, 6'd0);           // empty table
		send_word(CMD_SCHEDULE, '0, 5'd0, 6'd0);
		send_word(CMD_EVALUATE, '0, 5'd0, 6'd0);           // key zero cannot fire yet
		send_word(CMD_SCHEDULE, '0, 5'd0, 6'd0);           // already scheduled
		send_word(CMD_SCHEDULE, '1, 5'd23, 6'd59);
		send_word(CMD_SCHEDULE, k_morning, 5'd0, 6'd0);
		send_word(CMD_EVALUATE, '1, 5'd10, 6'd30);         // fires
		send_word(CMD_EVALUATE, '0, 5'd10, 6'd30);         // once only
		send_word(CMD_EVALUATE, '0, 5'd10, 6'd0);          // not due: drop the mark
		send_word(CMD_EVALUATE, '0, 5'd10, 6'd30);         // fires again
		send_word(CMD_EVALUATE, '0, 5'd0, 6'd0);           // key zero fires now
		send_word(CMD_UNSCHEDULE, '1, 5'd0, 6'd0);
		send_word(CMD_EVALUATE, '0, 5'd23, 6'd59);         // wraps to the first entry
		send_word(CMD_UNSCHEDULE, make_key(5'd1, 6'd2, 17'd3), 5'd0, 6'd0);
		send_word(CMD_RESCHEDULE, make_key(5'd1, 6'd2, 17'd3), 5'd4, 6'd5);
		send_word(CMD_RESCHEDULE, k_morning, 5'd23, 6'd59);
		send_word(CMD_SCHEDULE, k_seven, 5'd0, 6'd0);
		send_word(CMD_SCHEDULE, k_eight, 5'd0, 6'd0);
		send_word(CMD_RESCHEDULE, k_eight, 5'd7, 6'd0);    // lands on an equal key
		send_word(CMD_UNSCHEDULE, k_seven, 5'd0, 6'd0);    // one copy stays
		send_word(CMD_EVALUATE, '0, 5'd7, 6'd0);
		send_word(CMD_CLEAR, '0, 5'd0, 6'd0);
		send_word(CMD_EVALUATE, '0, 5'd7, 6'd0);
		// codes past clear do nothing
		for (int c = CMD_CLEAR + 1; c < 8; c++)
			send_word(CMD_W'(c), rand_key(), HOUR_W'($urandom_range(0, 23)),
				MIN_W'($urandom_range(0, 59)));
	endtask

	task automatic test_fill_and_drain();
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		send_word(CMD_CLEAR, '0, 5'd0, 6'd0);
		repeat (TABLE_DEPTH + 3)
			send_word(CMD_SCHEDULE, rand_key(), HOUR_W'($urandom_range(0, 23)),
				MIN_W'($urandom_range(0, 59)));
		for (int i = 0; i < sched_count; i++) begin
			entry_time(sched_keys[i], hour, minute);
			send_word(CMD_EVALUATE, KEY_W'($urandom), hour, minute);
		end
		while (sched_count > 0)
			send_word(CMD_UNSCHEDULE, sched_keys[$urandom_range(0, sched_count - 1)],
				5'd0, 6'd0);
	endtask

	// Stall the receiver for a long stretch while commands keep coming.
	task automatic test_backpressure();
		hold_request = 1'b1;
		repeat (12)
			send_word(CMD_SCHEDULE, rand_key(), HOUR_W'($urandom_range(0, 23)),
				MIN_W'($urandom_range(0, 59)));
		wait_drained();
	endtask

	task automatic test_random(input int items);
		int                pick;
		logic [CMD_W-1:0]  cmd;
		logic [KEY_W-1:0]  key;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		for (int n = 0; n < items; n++) begin
			pick   = $urandom_range(0, 99);
			key    = rand_key();
			hour   = HOUR_W'($urandom_range(0, 23));
			minute = ($urandom_range(0, 1) == 0) ? MIN_W'($urandom_range(0, 59))
				: MIN_W'($urandom_range(0, 3) * 15);
			if (pick < 35) begin
				cmd = CMD_SCHEDULE;
				if (sched_count > 0 && $urandom_range(0, 4) == 0)
					key = sched_keys[$urandom_range(0, sched_count - 1)];
			end else if (pick < 65) begin
				cmd = (pick < 50) ? CMD_UNSCHEDULE : CMD_RESCHEDULE;
				if (sched_count > 0 && $urandom_range(0, 4) != 0)
					key = sched_keys[$urandom_range(0, sched_count - 1)];
			end else if (pick < 97) begin
				cmd = CMD_EVALUATE;
				if (sched_count > 0 && $urandom_range(0, 2) != 0)
					entry_time(sched_keys[$urandom_range(0, sched_count - 1)], hour, minute);
			end else begin
				cmd = CMD_CLEAR;
			end
			send_word(cmd, key, hour, minute);
			if ($urandom_range(0, 149) == 0)
				wait_drained();
		end
	endtask

	// Receiver: cycle through always-ready, random, mostly-ready and sparse phases.
	initial begin
		int unsigned rx_cycle;
		rx_cycle      = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_count++;
			end
			rx_cycle++;
			case ((rx_cycle >> 6) % 4)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= (rx_cycle % 5) != 0;
			default: m_axis_tready <= (rx_cycle % 7) == 0;
			endcase
		end
	end

	// Check every result word against the oldest owed result.
	always @(posedge clk) begin
		alarm_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_count++;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
			end else begin
				want = awaited_results.pop_front();
				if (m_axis_tdata[STAT_W-1:0] !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						m_axis_tdata[STAT_W-1:0], want.status));
				if (m_axis_tdata[FIRE_BIT] !== want.fire)
					report_mismatch($sformatf("fire %b, expected %b",
						m_axis_tdata[FIRE_BIT], want.fire));
				if (m_axis_tdata[RKEY_LO-1:PAY_LO] !== want.payload)
					report_mismatch($sformatf("fire_payload %h, expected %h",
						m_axis_tdata[RKEY_LO-1:PAY_LO], want.payload));
				if (m_axis_tdata[M_DATA_W-1:RKEY_LO] !== want.new_key)
					report_mismatch($sformatf("result_key %h, expected %h",
						m_axis_tdata[M_DATA_W-1:RKEY_LO], want.new_key));
			end
		end
	end

	// Abort when no word moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stuck_cycles = 0;
		end else if (++stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		sched_count    = 0;
		fired_key      = '0;
		fire_count     = 0;
		full_count     = 0;
		result_count   = 0;
		mismatch_count = 0;
		hold_count     = 0;
		burst_left     = 0;
		stuck_cycles   = 0;
		hold_request   = 1'b0;
		foreach (cmd_count[i])
			cmd_count[i] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_backpressure();
		test_random(RANDOM_ITEMS);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived",
				awaited_results.size()));

		$display("covered %0d words: %0d schedule, %0d unschedule, %0d reschedule,",
			result_count, cmd_count[CMD_SCHEDULE], cmd_count[CMD_UNSCHEDULE],
			cmd_count[CMD_RESCHEDULE]);
		$display("%0d evaluate, %0d clear; %0d events fired, %0d refused on a full table, %0d long receiver holds",
			cmd_count[CMD_EVALUATE], cmd_count[CMD_CLEAR], fire_count, full_count, hold_count);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
